[sv/ic4n_pkg.sv]
package ic4n_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W  = 8;
   localparam int CFG_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);

   localparam logic [CFG_W-1:0] LINE_WIDTH_RESET    = CFG_W'(512);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET  = CFG_W'(512);
   localparam logic [PIX_W-1:0] CONTOUR_VALUE_RESET = PIX_W'(255);

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CONTOUR_VALUE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] contour_pixel;
      logic             end_of_row;
      logic             end_of_frame;
   } rsp_type;

   // write and read-address side of the row flag store
   typedef struct packed {
      logic             mid_we;
      logic             up_we;
      logic [COL_W-1:0] wr_addr;
      logic             mid_bit;
      logic             up_bit;
      logic [COL_W-1:0] rd_addr;
   } flag_access_type;

   typedef struct packed {
      logic centre;
      logic right;
      logic above;
   } flag_read_type;

   function automatic logic [WSZ_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      logic [WSZ_W-1:0] r;
      if (v == '0) begin
         r = WSZ_W'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         r = WSZ_W'(MAX_WIDTH);
      end else begin
         r = WSZ_W'(v);
      end
      return r;
   endfunction

   function automatic logic [HSZ_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      logic [HSZ_W-1:0] r;
      if (v == '0) begin
         r = HSZ_W'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         r = HSZ_W'(MAX_HEIGHT);
      end else begin
         r = HSZ_W'(v);
      end
      return r;
   endfunction

endpackage

[sv/ic4n_if.sv]
interface ic4n_req_if;
   import ic4n_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;
   logic             flush;

   modport source (output valid, output pixel_value, output flush, input ready);
   modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

interface ic4n_rsp_if;
   import ic4n_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] contour_pixel;
   logic             end_of_row;
   logic             end_of_frame;

   modport source (output valid, output contour_pixel, output end_of_row,
                   output end_of_frame, input ready);
   modport sink   (input valid, input contour_pixel, input end_of_row,
                   input end_of_frame, output ready);
endinterface

[sv/inner_contour_4_neighbour.sv]
// Inner contour of a binary mask, 4-connected, streaming.
// req_chan carries one mask pixel per request in raster order (nonzero means
// inside the object); rsp_chan returns one result per pixel: contour_value on
// pixels that are set and touch a zero 4-neighbour inside the image, else 0,
// with end_of_row / end_of_frame marks.
// A pixel's result is computed when the pixel below it arrives, so the first
// row yields nothing and the caller sends one row of flush requests after the
// last row to drain it. A flush request during a pixel row is dropped.
// Throughput is one request per cycle while the output buffer has space; a
// result is registered and shown on rsp_chan behind any result still held.
// Row flags live in two 1-bit RAMs read every cycle one step ahead of the
// pixel stream, with write forwarding for narrow images.
// A two-entry output buffer keeps req_chan.ready high while one result waits;
// req_chan.ready drops only when both entries are held by a stalled receiver.
// Reset clears the position counters and the output buffer and loads the
// default size 512 x 512 and contour value 255; the row RAMs are not cleared.
// csr_* writes take effect at once and are to be done between frames.
module inner_contour_4_neighbour (
   input  logic                         clock,
   input  logic                         reset,
   ic4n_req_if.sink                     req_chan,
   ic4n_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  ic4n_pkg::csr_index_type      csr_index,
   input  logic [ic4n_pkg::CFG_W-1:0]   csr_wr_data
);
   import ic4n_pkg::*;

   logic [CFG_W-1:0] line_width_ff;
   logic [CFG_W-1:0] line_width_in;
   logic [CFG_W-1:0] frame_height_ff;
   logic [CFG_W-1:0] frame_height_in;
   logic [PIX_W-1:0] contour_value_ff;
   logic [PIX_W-1:0] contour_value_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [HSZ_W-1:0] row_ff;
   logic [HSZ_W-1:0] row_in;
   logic             left_ff;

   logic [WSZ_W-1:0] w;
   logic [WSZ_W-1:0] w_next;
   logic [HSZ_W-1:0] h;
   logic [COL_W-1:0] x;
   logic [COL_W-1:0] next_x;
   logic [HSZ_W-1:0] row;
   logic             accept;
   logic             act;
   logic             last_col;
   logic             pix;
   logic             n_above;
   logic             n_below;
   logic             n_left;
   logic             n_right;
   logic             is_edge;
   logic             space;
   logic             push;

   flag_access_type  acc;
   flag_read_type    rd;
   rsp_type          result;

   // configuration registers
   always_comb begin
      line_width_in    = line_width_ff;
      frame_height_in  = frame_height_ff;
      contour_value_in = contour_value_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:    line_width_in    = csr_wr_data;
            CSR_FRAME_HEIGHT:  frame_height_in  = csr_wr_data;
            CSR_CONTOUR_VALUE: contour_value_in = csr_wr_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // current position, clamped to the configured size
   assign w   = clamp_width(line_width_ff);
   assign h   = clamp_height(frame_height_ff);
   assign x   = (WSZ_W'(col_ff) >= w) ? COL_W'(w - WSZ_W'(1)) : col_ff;
   assign row = (row_ff > h) ? h : row_ff;

   assign req_chan.ready = space;
   assign accept   = req_chan.valid && req_chan.ready;
   // drop a flush during a pixel row
   assign act      = accept && !(row < h && req_chan.flush);
   assign last_col = (WSZ_W'(x) == w - WSZ_W'(1));
   assign pix      = (row < h) && (req_chan.pixel_value != '0);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (act) begin
         if (last_col) begin
            col_in = '0;
            row_in = (row == h) ? '0 : row + HSZ_W'(1);
         end else begin
            col_in = x + COL_W'(1);
            row_in = row;
         end
      end
   end

   // read address for the next request, seen through the next size setting
   assign w_next = clamp_width(line_width_in);
   assign next_x = (WSZ_W'(col_in) >= w_next) ? COL_W'(w_next - WSZ_W'(1)) : col_in;

   always_comb begin
      acc.mid_we  = act;
      acc.up_we   = act && (row != '0);
      acc.wr_addr = x;
      acc.mid_bit = pix;
      acc.up_bit  = rd.centre;
      acc.rd_addr = next_x;
   end

   ic4n_row_store u_row_store (
      .clock (clock),
      .acc   (acc),
      .rd    (rd)
   );

   // neighbours outside the image count as set
   assign n_above = (row >= HSZ_W'(2)) ? rd.above : 1'b1;
   assign n_below = (row < h) ? pix : 1'b1;
   assign n_left  = (x != '0) ? left_ff : 1'b1;
   assign n_right = ((WSZ_W'(x) + WSZ_W'(1)) < w) ? rd.right : 1'b1;
   assign is_edge = rd.centre && !(n_above && n_below && n_left && n_right);

   assign push                 = act && (row != '0);
   assign result.contour_pixel = is_edge ? contour_value_ff : '0;
   assign result.end_of_row    = last_col;
   assign result.end_of_frame  = last_col && (row == h);

   ic4n_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .space     (space),
      .rsp_chan  (rsp_chan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= LINE_WIDTH_RESET;
         frame_height_ff  <= FRAME_HEIGHT_RESET;
         contour_value_ff <= CONTOUR_VALUE_RESET;
         col_ff           <= '0;
         row_ff           <= '0;
      end else begin
         line_width_ff    <= line_width_in;
         frame_height_ff  <= frame_height_in;
         contour_value_ff <= contour_value_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
      end
   end

   // hold the centre flag of this pixel as the left neighbour of the next
   always_ff @(posedge clock) begin
      if (push) begin
         left_ff <= rd.centre;
      end
   end

endmodule

[sv/ic4n_row_store.sv]
module ic4n_row_store (
   input  logic                      clock,
   input  ic4n_pkg::flag_access_type acc,
   output ic4n_pkg::flag_read_type   rd
);
   import ic4n_pkg::*;

   logic mid_mem [MAX_WIDTH];
   logic up_mem  [MAX_WIDTH];

   logic [COL_W-1:0] rd_next;
   logic             centre_ff;
   logic             right_ff;
   logic             above_ff;

   // right neighbour sits one entry ahead; wraps harmlessly on the last column
   assign rd_next = acc.rd_addr + COL_W'(1);

   always_ff @(posedge clock) begin
      if (acc.mid_we) begin
         mid_mem[acc.wr_addr] <= acc.mid_bit;
      end
      if (acc.up_we) begin
         up_mem[acc.wr_addr] <= acc.up_bit;
      end
   end

   // read every cycle; forward the write of the same edge on an address match
   always_ff @(posedge clock) begin
      if (acc.mid_we && acc.wr_addr == acc.rd_addr) begin
         centre_ff <= acc.mid_bit;
      end else begin
         centre_ff <= mid_mem[acc.rd_addr];
      end
      if (acc.mid_we && acc.wr_addr == rd_next) begin
         right_ff <= acc.mid_bit;
      end else begin
         right_ff <= mid_mem[rd_next];
      end
      if (acc.up_we && acc.wr_addr == acc.rd_addr) begin
         above_ff <= acc.up_bit;
      end else begin
         above_ff <= up_mem[acc.rd_addr];
      end
   end

   assign rd.centre = centre_ff;
   assign rd.right  = right_ff;
   assign rd.above  = above_ff;

endmodule

[sv/ic4n_out_buf.sv]
module ic4n_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ic4n_pkg::rsp_type push_data,
   output logic              space,
   ic4n_rsp_if.source        rsp_chan
);
   import ic4n_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;
   rsp_type    head;

   assign space = (count_ff != 2'd2);
   assign pop   = rsp_chan.valid && rsp_chan.ready;
   assign head  = entry_ff[rd_ptr_ff];

   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.contour_pixel = head.contour_pixel;
   assign rsp_chan.end_of_row    = head.end_of_row;
   assign rsp_chan.end_of_frame  = head.end_of_frame;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
